/* src/multi_button_debounce_hold_unit_assert.svh */
// Assertion macros for the multi-button debounce and hold unit.
// Expect signals named clk and rst_n in the scope where a macro is used.
`ifndef MULTI_BUTTON_DEBOUNCE_HOLD_UNIT_ASSERT_SVH
`define MULTI_BUTTON_DEBOUNCE_HOLD_UNIT_ASSERT_SVH

// same-cycle implication
`define MBDH_ASSERT_SAME(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("mbdh: same-cycle check failed");

// next-cycle implication
`define MBDH_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("mbdh: next-cycle check failed");

`endif

/* src/mbdh_pkg.sv */
// Shared types and constants for the multi-button debounce and hold unit.
// No dependencies.
package mbdh_pkg;

    localparam int PIN_COUNT       = 18;
    localparam int GROUP_BUTTONS   = 8;
    localparam int GROUP_JACKS     = 10;

    localparam int KIND_W          = 2;
    localparam int LEVEL_W         = 2;
    localparam int ID_W            = 5;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 18;
    localparam int CFG_BYTE_W      = 8;

    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [LEVEL_W-1:0] level_t;

    localparam kind_t KIND_TICK      = 2'd0;
    localparam kind_t KIND_GET_NEW   = 2'd1;
    localparam kind_t KIND_GET_STATE = 2'd2;
    localparam kind_t KIND_RANGE     = 2'd3;

    localparam level_t LVL_RELEASED  = 2'd0;
    localparam level_t LVL_PRESSED   = 2'd1;
    localparam level_t LVL_HELD      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_DEBOUNCE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_JACK_DEBOUNCE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MASK       = 3'd4;

    localparam logic [CFG_BYTE_W-1:0] RST_BUTTON_DEBOUNCE = 8'd5;
    localparam logic [CFG_BYTE_W-1:0] RST_JACK_DEBOUNCE   = 8'd20;
    localparam logic [CFG_BYTE_W-1:0] RST_SWITCH_DEBOUNCE = 8'd10;
    localparam logic [CFG_BYTE_W-1:0] RST_HOLD_TICKS      = 8'd100;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_MASK       = 18'h000FF;

endpackage

/* src/multi_button_debounce_hold_unit.sv */
// Multi-button debounce and hold unit: top level.
// Depends on mbdh_pkg and multi_button_debounce_hold_unit_assert.svh.
//
// Usage:
//   s_* channel takes one request per transaction. s_tuser is the kind
//   (tick, get next new event, get channel state, range query); s_tdata
//   carries the raw pin levels and the one-based channel select.
//   m_* channel returns exactly one result per request.
//   cfg_we/cfg_index/cfg_wdata write the timing registers; write only while idle.
//   Per-channel state lives in one synchronous RAM; each request walks its
//   entries one per cycle through a read, modify and write-back stage.
//   A tick walks every entry, a get-new query the first min(NUM_EVENT_CHANNELS,
//   NUM_CHANNELS), a get-state query only the selected one (none when the
//   select is zero or out of range), a range query those from zero-based index
//   NUM_EVENT_CHANNELS on. The next request is taken only after the result
//   has gone into the output register.
//   Reset clears all channel state at once through per-entry valid bits and
//   loads the register defaults; no clearing pass is needed.
//   A stalled result holds in the output register; the next request is still
//   accepted and worked, and its result waits until the output register frees.
module multi_button_debounce_hold_unit
    import mbdh_pkg::*;
#(
    parameter int NUM_CHANNELS       = 18,
    parameter int NUM_EVENT_CHANNELS = 10,
    parameter int TIMER_BITS         = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // pins_n[17:0], button_select[22:18], zero pad
    input  logic [KIND_W-1:0]     s_tuser,   // kind[1:0]

    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // button_id[4:0], button_level[6:5], state_changed[7]

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW    = $clog2(NUM_CHANNELS);
    localparam int EVT_N = (NUM_EVENT_CHANNELS < NUM_CHANNELS) ? NUM_EVENT_CHANNELS
                                                               : NUM_CHANNELS;
    localparam logic [AW-1:0] NC_LAST   = AW'(NUM_CHANNELS - 1);
    localparam logic [AW-1:0] EVT_LAST  = AW'(EVT_N - 1);
    localparam logic [AW-1:0] RNG_FIRST = AW'(NUM_EVENT_CHANNELS);
    localparam logic [6:0]    NC_COUNT  = 7'(NUM_CHANNELS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_TAIL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    typedef struct packed {
        logic                  sample;
        level_t                level;
        logic                  flag;
        logic [TIMER_BITS-1:0] dcount;
        logic [TIMER_BITS-1:0] hcount;
    } entry_t;

    // configuration registers
    logic [CFG_BYTE_W-1:0] button_debounce_reg;
    logic [CFG_BYTE_W-1:0] jack_debounce_reg;
    logic [CFG_BYTE_W-1:0] switch_debounce_reg;
    logic [CFG_BYTE_W-1:0] hold_ticks_reg;
    logic [CFG_DATA_W-1:0] hold_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_debounce_reg <= RST_BUTTON_DEBOUNCE;
            jack_debounce_reg   <= RST_JACK_DEBOUNCE;
            switch_debounce_reg <= RST_SWITCH_DEBOUNCE;
            hold_ticks_reg      <= RST_HOLD_TICKS;
            hold_mask_reg       <= RST_HOLD_MASK;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BUTTON_DEBOUNCE: button_debounce_reg <= cfg_wdata[CFG_BYTE_W-1:0];
                REG_JACK_DEBOUNCE:   jack_debounce_reg   <= cfg_wdata[CFG_BYTE_W-1:0];
                REG_SWITCH_DEBOUNCE: switch_debounce_reg <= cfg_wdata[CFG_BYTE_W-1:0];
                REG_HOLD_TICKS:      hold_ticks_reg      <= cfg_wdata[CFG_BYTE_W-1:0];
                REG_HOLD_MASK:       hold_mask_reg       <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // control and request registers
    logic [1:0]           state_reg, state_next;
    kind_t                kind_reg;
    logic [PIN_COUNT-1:0] pins_reg;
    logic [AW-1:0]        cur_reg, last_reg;
    logic                 p_valid_reg;
    logic [AW-1:0]        p_addr_reg;
    logic                 found_reg, found_next;
    logic                 multi_reg, multi_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;
    level_t               res_level_reg, res_level_next;
    logic                 res_chg_reg, res_chg_next;
    logic                 m_valid_reg;
    logic [7:0]           m_data_reg;

    logic                 accept;
    logic [ID_W-1:0]      sel;
    logic                 out_free;

    // state RAM with per-entry valid bits
    entry_t               mem [NUM_CHANNELS];
    entry_t               mem_q;
    logic [NUM_CHANNELS-1:0] valid_reg;
    logic                 rd_en;
    logic                 wr_en;
    entry_t               e_cur, e_new;

    // per-channel pin and hold-enable views
    logic [NUM_CHANNELS-1:0] pin_vec;
    logic [NUM_CHANNELS-1:0] hold_vec;

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        if (i < PIN_COUNT)
        begin : g_pin
            assign pin_vec[i]  = ~pins_reg[i];
            assign hold_vec[i] = hold_mask_reg[i];
        end
        else
        begin : g_nopin
            assign pin_vec[i]  = 1'b0;
            assign hold_vec[i] = 1'b0;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign sel      = s_tdata[22:18];
    assign out_free = !m_valid_reg || m_tready;
    assign rd_en    = (state_reg == S_SCAN);

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_q <= mem[cur_reg];
        end
        if (wr_en)
        begin
            mem[p_addr_reg] <= e_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[p_addr_reg] <= 1'b1;
        end
    end

    // read, modify and write back one entry
    logic [TIMER_BITS-1:0] db_load;
    logic [ID_W-1:0]       ch_id;
    logic                  pressed;

    always_comb
    begin
        e_cur          = valid_reg[p_addr_reg] ? mem_q : '0;
        e_new          = e_cur;
        wr_en          = 1'b0;
        found_next     = found_reg;
        multi_next     = multi_reg;
        res_id_next    = res_id_reg;
        res_level_next = res_level_reg;
        res_chg_next   = res_chg_reg;
        ch_id          = ID_W'({1'b0, p_addr_reg} + 1'b1);
        pressed        = pin_vec[p_addr_reg];
        if (p_addr_reg < AW'(GROUP_BUTTONS))
        begin
            db_load = TIMER_BITS'(button_debounce_reg);
        end
        else if (p_addr_reg < AW'(GROUP_JACKS))
        begin
            db_load = TIMER_BITS'(jack_debounce_reg);
        end
        else
        begin
            db_load = TIMER_BITS'(switch_debounce_reg);
        end
        if (p_valid_reg)
        begin
            case (kind_reg)
                KIND_TICK:
                begin
                    wr_en = 1'b1;
                    if (pressed == e_cur.sample)
                    begin
                        if (e_cur.dcount != '0)
                        begin
                            e_new.dcount = e_cur.dcount - 1'b1;
                            if (e_new.dcount == '0)
                            begin
                                e_new.level  = pressed ? LVL_PRESSED : LVL_RELEASED;
                                e_new.flag   = 1'b1;
                                e_new.hcount = TIMER_BITS'(hold_ticks_reg);
                                res_chg_next = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        e_new.dcount = db_load;
                    end
                    e_new.sample = pressed;
                    if (hold_vec[p_addr_reg] && e_new.level == LVL_PRESSED
                        && e_new.hcount != '0)
                    begin
                        e_new.hcount = e_new.hcount - 1'b1;
                        if (e_new.hcount == '0)
                        begin
                            e_new.level  = LVL_HELD;
                            e_new.flag   = 1'b1;
                            res_chg_next = 1'b1;
                        end
                    end
                end
                KIND_GET_NEW:
                begin
                    if (e_cur.flag && !found_reg)
                    begin
                        found_next     = 1'b1;
                        res_id_next    = ch_id;
                        res_level_next = e_cur.level;
                        e_new.flag     = 1'b0;
                        wr_en          = 1'b1;
                    end
                end
                KIND_GET_STATE:
                begin
                    res_level_next = e_cur.level;
                    e_new.flag     = 1'b0;
                    wr_en          = 1'b1;
                end
                KIND_RANGE:
                begin
                    if (e_cur.level == LVL_PRESSED)
                    begin
                        if (found_reg)
                        begin
                            multi_next = 1'b1;
                        end
                        else
                        begin
                            found_next  = 1'b1;
                            res_id_next = ch_id;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (s_tuser)
                        KIND_GET_STATE:
                            state_next = (sel != '0 && 7'(sel) <= NC_COUNT) ? S_SCAN : S_DONE;
                        KIND_RANGE:
                            state_next = (NUM_EVENT_CHANNELS < NUM_CHANNELS) ? S_SCAN : S_DONE;
                        default:
                            state_next = S_SCAN;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (cur_reg == last_reg)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            p_valid_reg <= rd_en;
            if (state_reg == S_DONE && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg      <= s_tuser;
            pins_reg      <= s_tdata[PIN_COUNT-1:0];
            found_reg     <= 1'b0;
            multi_reg     <= 1'b0;
            res_id_reg    <= '0;
            res_level_reg <= LVL_RELEASED;
            res_chg_reg   <= 1'b0;
            case (s_tuser)
                KIND_GET_NEW:
                begin
                    cur_reg  <= '0;
                    last_reg <= EVT_LAST;
                end
                KIND_GET_STATE:
                begin
                    cur_reg  <= AW'(sel - 1'b1);
                    last_reg <= AW'(sel - 1'b1);
                end
                KIND_RANGE:
                begin
                    cur_reg  <= RNG_FIRST;
                    last_reg <= NC_LAST;
                end
                default:
                begin
                    cur_reg  <= '0;
                    last_reg <= NC_LAST;
                end
            endcase
        end
        else
        begin
            found_reg     <= found_next;
            multi_reg     <= multi_next;
            res_id_reg    <= res_id_next;
            res_level_reg <= res_level_next;
            res_chg_reg   <= res_chg_next;
            if (rd_en)
            begin
                cur_reg <= cur_reg + 1'b1;
            end
        end
        if (rd_en)
        begin
            p_addr_reg <= cur_reg;
        end
        if (state_reg == S_DONE && out_free)
        begin
            m_data_reg <= {res_chg_reg, res_level_reg, multi_reg ? ID_W'(0) : res_id_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`include "multi_button_debounce_hold_unit_assert.svh"

    `MBDH_ASSERT_SAME(a_no_rw_overlap, rd_en && wr_en, cur_reg != p_addr_reg)
    `MBDH_ASSERT_SAME(a_write_in_walk, wr_en, state_reg == S_SCAN || state_reg == S_TAIL)
    `MBDH_ASSERT_SAME(a_level_code, m_valid_reg,
        m_data_reg[6:5] == LVL_RELEASED || m_data_reg[6:5] == LVL_PRESSED ||
        m_data_reg[6:5] == LVL_HELD)
    `MBDH_ASSERT_NEXT(a_result_from_done, state_reg == S_DONE && out_free,
        m_valid_reg && state_reg == S_IDLE)

endmodule
